[rtl/core/rc_receiver_frame_sync_decode_top_macros.svh]
// ----------------------------------------------------------------------------
// rc_receiver_frame_sync_decode_top_macros.svh
// Assertion macros used by the frame decoder checker.
// ----------------------------------------------------------------------------
`ifndef RC_RECEIVER_FRAME_SYNC_DECODE_TOP_MACROS_SVH
`define RC_RECEIVER_FRAME_SYNC_DECODE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define RCFS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("rcfs: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define RCFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("rcfs: next-cycle check failed");

`endif

[rtl/core/rcfs_pkg.sv]
// ----------------------------------------------------------------------------
// rcfs_pkg
// Types and constants for the 18-byte remote-control frame decoder.
// ----------------------------------------------------------------------------
package rcfs_pkg;

  // Frame geometry
  localparam int FRAME_BYTES = 18;
  // Only the first FRAME_BYTES-1 bytes are stored; the last one is the incoming byte
  localparam int WIN_DEPTH   = FRAME_BYTES - 1;
  localparam int FILL_W      = $clog2(FRAME_BYTES);

  // Field widths
  localparam int CHAN_W  = 11;
  localparam int SW_W    = 2;
  localparam int WORD_W  = 16;

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Register reset values
  localparam logic [CHAN_W-1:0] CHANNEL_MIN_RST = 11'd364;
  localparam logic [CHAN_W-1:0] CHANNEL_MAX_RST = 11'd1684;

  // Fill level at which the incoming byte completes a frame
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(WIN_DEPTH);

  typedef logic [7:0]        byte_t;
  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [SW_W-1:0]   sw_t;
  typedef logic [FILL_W-1:0] fill_t;

  // Register index, taken from byte address bit 2
  typedef enum logic [0:0] {
    REG_CHANNEL_MIN = 1'b0,
    REG_CHANNEL_MAX = 1'b1
  } reg_idx_t;

endpackage

[rtl/core/rc_receiver_frame_sync_decode_top.sv]
// ----------------------------------------------------------------------------
// rc_receiver_frame_sync_decode_top
// Remote-control receiver frame sync and decode: collects serial bytes into
// an 18-byte window, checks each full window and decodes passing frames.
// ----------------------------------------------------------------------------
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  input    | in_valid/in_ready   | in_rx_byte
//  result   | out_valid/out_ready | out_chan0..4, switches, mouse, key_mask
//  config   | psel/penable/...    | paddr, pwdata, prdata (0x0 min, 0x4 max)
//
//  One byte is taken every cycle while in_ready is high; a result appears in
//  the cycle after the byte that completes a passing frame.
//  The window and the frame check sit in front of a single result register.
//  in_ready drops only while a result waits in that register and out_ready
//  is low. Reset (synchronous, rst_n low) empties the window, clears the
//  result valid flag and restores the channel limits.
// ----------------------------------------------------------------------------
module rc_receiver_frame_sync_decode_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          in_rx_byte,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rcfs_pkg::CHAN_W-1:0]         out_chan0,
  output logic [rcfs_pkg::CHAN_W-1:0]         out_chan1,
  output logic [rcfs_pkg::CHAN_W-1:0]         out_chan2,
  output logic [rcfs_pkg::CHAN_W-1:0]         out_chan3,
  output logic [rcfs_pkg::CHAN_W-1:0]         out_chan4,
  output logic [rcfs_pkg::SW_W-1:0]           out_switch_left,
  output logic [rcfs_pkg::SW_W-1:0]           out_switch_right,
  output logic signed [rcfs_pkg::WORD_W-1:0]  out_mouse_x,
  output logic signed [rcfs_pkg::WORD_W-1:0]  out_mouse_y,
  output logic signed [rcfs_pkg::WORD_W-1:0]  out_mouse_z,
  output logic [rcfs_pkg::WORD_W-1:0]         out_mouse_buttons,
  output logic [rcfs_pkg::WORD_W-1:0]         out_key_mask,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rcfs_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [rcfs_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [rcfs_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  // Configuration registers
  rcfs_pkg::chan_t    channel_min_r;
  rcfs_pkg::chan_t    channel_max_r;
  rcfs_pkg::reg_idx_t reg_sel;
  logic               cfg_wr;

  // Window storage and fill count
  rcfs_pkg::byte_t    win_r   [rcfs_pkg::WIN_DEPTH];
  rcfs_pkg::byte_t    win_nxt [rcfs_pkg::WIN_DEPTH];
  rcfs_pkg::fill_t    fill_r;
  rcfs_pkg::fill_t    fill_nxt;

  // Frame check and result register control
  logic               in_acc;
  logic               frame_full;
  logic               frame_ok;
  logic               res_load;
  logic               out_valid_r;
  logic               out_valid_nxt;
  rcfs_pkg::chan_t    chan0_c;
  rcfs_pkg::sw_t      sw_left_c;
  rcfs_pkg::sw_t      sw_right_c;

  // ------------------------------------------------------------------
  // Configuration port
  // ------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_sel = rcfs_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_min_r <= rcfs_pkg::CHANNEL_MIN_RST;
      channel_max_r <= rcfs_pkg::CHANNEL_MAX_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        rcfs_pkg::REG_CHANNEL_MIN: channel_min_r <= pwdata[rcfs_pkg::CHAN_W-1:0];
        rcfs_pkg::REG_CHANNEL_MAX: channel_max_r <= pwdata[rcfs_pkg::CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the selected limit, zero-extended
  always_comb begin
    case (reg_sel)
      rcfs_pkg::REG_CHANNEL_MIN:
        prdata = rcfs_pkg::APB_DATA_W'(channel_min_r);
      rcfs_pkg::REG_CHANNEL_MAX:
        prdata = rcfs_pkg::APB_DATA_W'(channel_max_r);
      default:
        prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------
  // Frame check: the incoming byte completes the frame when 17 are held.
  // Channel 0 and the switches come from stored bytes only.
  // ------------------------------------------------------------------
  assign in_ready   = !out_valid_r || out_ready;
  assign in_acc     = in_valid && in_ready;
  assign frame_full = (fill_r == rcfs_pkg::FILL_LAST);

  assign chan0_c    = {win_r[1][2:0], win_r[0]};
  assign sw_left_c  = win_r[5][5:4];
  assign sw_right_c = win_r[5][7:6];

  assign frame_ok = (chan0_c >= channel_min_r) && (chan0_c <= channel_max_r) &&
                    (sw_left_c != '0) && (sw_right_c != '0);

  assign res_load = in_acc && frame_full && frame_ok;

  // ------------------------------------------------------------------
  // Window update: append, empty on a good frame, slide on a bad one
  // ------------------------------------------------------------------
  always_comb begin
    win_nxt  = win_r;
    fill_nxt = fill_r;
    if (in_acc) begin
      if (!frame_full) begin
        win_nxt[fill_r] = in_rx_byte;
        fill_nxt        = fill_r + 1'b1;
      end else if (frame_ok) begin
        fill_nxt = '0;
      end else begin
        // drop the oldest byte, the incoming one becomes the newest stored
        for (int j = 0; j < rcfs_pkg::WIN_DEPTH - 1; j++) begin
          win_nxt[j] = win_r[j+1];
        end
        win_nxt[rcfs_pkg::WIN_DEPTH-1] = in_rx_byte;
        fill_nxt = rcfs_pkg::FILL_LAST;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  // ------------------------------------------------------------------
  // Result register: load on a passing frame, hold while stalled
  // ------------------------------------------------------------------
  always_comb begin
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Decode the frame; byte 17 is the incoming byte
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_chan0         <= chan0_c;
      out_chan1         <= {win_r[2][5:0], win_r[1][7:3]};
      out_chan2         <= {win_r[4][0], win_r[3], win_r[2][7:6]};
      out_chan3         <= {win_r[5][3:0], win_r[4][7:1]};
      out_chan4         <= {in_rx_byte[2:0], win_r[16]};
      out_switch_left   <= sw_left_c;
      out_switch_right  <= sw_right_c;
      out_mouse_x       <= $signed({win_r[7], win_r[6]});
      out_mouse_y       <= $signed({win_r[9], win_r[8]});
      out_mouse_z       <= $signed({win_r[11], win_r[10]});
      out_mouse_buttons <= {win_r[13], win_r[12]};
      out_key_mask      <= {win_r[15], win_r[14]};
    end
  end

  assign out_valid = out_valid_r;

endmodule

[rtl/core/rcfs_checker.sv]
// ----------------------------------------------------------------------------
// rcfs_checker
// Port-level checks for the frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "rc_receiver_frame_sync_decode_top_macros.svh"

module rcfs_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [rcfs_pkg::CHAN_W-1:0]         out_chan0,
  input  logic [rcfs_pkg::CHAN_W-1:0]         out_chan1,
  input  logic [rcfs_pkg::CHAN_W-1:0]         out_chan2,
  input  logic [rcfs_pkg::CHAN_W-1:0]         out_chan3,
  input  logic [rcfs_pkg::CHAN_W-1:0]         out_chan4,
  input  logic [rcfs_pkg::SW_W-1:0]           out_switch_left,
  input  logic [rcfs_pkg::SW_W-1:0]           out_switch_right,
  input  logic signed [rcfs_pkg::WORD_W-1:0]  out_mouse_x,
  input  logic signed [rcfs_pkg::WORD_W-1:0]  out_mouse_y,
  input  logic signed [rcfs_pkg::WORD_W-1:0]  out_mouse_z,
  input  logic [rcfs_pkg::WORD_W-1:0]         out_mouse_buttons,
  input  logic [rcfs_pkg::WORD_W-1:0]         out_key_mask
);

  localparam int PAYLOAD_W = 5 * rcfs_pkg::CHAN_W + 2 * rcfs_pkg::SW_W +
                             5 * rcfs_pkg::WORD_W;

  // Whole result payload, watched as one word
  logic [PAYLOAD_W-1:0] out_payload;

  assign out_payload = {out_chan0, out_chan1, out_chan2, out_chan3, out_chan4,
                        out_switch_left, out_switch_right,
                        out_mouse_x, out_mouse_y, out_mouse_z,
                        out_mouse_buttons, out_key_mask};

  // Hold a stalled result
  `RCFS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // A stalled result keeps its payload
  `RCFS_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_payload))

  // A new result follows an accepted byte
  `RCFS_ASSERT_SAME(a_out_cause, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready))

  // A delivered frame passed the switch check
  `RCFS_ASSERT_SAME(a_out_switch, clk, rst_n, out_valid, (|out_switch_left) && (|out_switch_right))

  // An empty result register never stalls the input
  `RCFS_ASSERT_SAME(a_in_free, clk, rst_n, !out_valid, in_ready)

endmodule

bind rc_receiver_frame_sync_decode_top rcfs_checker u_rcfs_checker (.*);
